### src/bayer_quad_to_rgb_decimator_unit_defines.svh
// assertion macros shared by the decimator rtl
`ifndef BAYER_QUAD_TO_RGB_DECIMATOR_UNIT_DEFINES_SVH
`define BAYER_QUAD_TO_RGB_DECIMATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define BQRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define BQRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bqrd_pkg.sv
// types, constants and helpers for the bayer quad decimator
package bqrd_pkg;

    localparam int CFG_W            = 13;
    localparam int ROW_W            = 12;
    localparam int MAX_FRAME_HEIGHT = 4096;

    localparam logic [7:0]       CLIP_LIMIT         = 8'hff;
    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 13'd1280;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd720;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_LINE_WIDTH   = 1'b0;
    localparam cfg_index_t REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [15:0] raw_pixel;
        logic        frame_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_end;
    } out_item_t;

    // what the current sample does, from its position in the mosaic
    typedef struct packed {
        logic load_blue;
        logic store_pair;
        logic emit;
        logic frame_end;
    } ctrl_flags_t;

    function automatic logic [7:0] clip8(input logic [15:0] v);
        return (|v[15:8]) ? CLIP_LIMIT : v[7:0];
    endfunction

endpackage

### src/bayer_quad_to_rgb_decimator_unit.sv
// channel   | direction | payload     | handshake
// s_        | in        | in_item_t   | s_valid / s_ready
// m_        | out       | out_item_t  | m_valid / m_ready
// cfg_      | in        | size write  | cfg_we, no wait
// one raw sample per cycle unless stalled; each odd-row odd-column sample yields a result
// the line store ram (one write, one read port) is touched at most once per sample
// synchronous reset clears counters, sets default sizes; the line store is not cleared
// input stalls only when a result is pending and the output register is blocked
module bayer_quad_to_rgb_decimator_unit import bqrd_pkg::*; #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

`include "bayer_quad_to_rgb_decimator_unit_defines.svh"

    localparam int SW    = $clog2(MAX_LINE_WIDTH) - 1;
    localparam int DEPTH = MAX_LINE_WIDTH / 2;

    logic [SW-1:0] slot;
    ctrl_flags_t   flags;
    logic          accept, out_free, out_load;
    logic [7:0]    sample;
    logic [15:0]   pair;

    logic [7:0] held_blue_reg, held_blue_next;
    logic       p1_valid_reg, p1_valid_next;
    logic [7:0] p1_red_reg;
    logic       p1_fe_reg;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg;

    bqrd_ctrl #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .advance     (accept),
        .frame_start (s_data.frame_start),
        .slot        (slot),
        .flags       (flags)
    );

    // writes happen on even rows, reads on odd rows; a read never follows
    // its write in the next transaction, so no forwarding path is needed
    bqrd_ram #(
        .WIDTH(16),
        .DEPTH(DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (accept && flags.store_pair),
        .wr_addr (slot),
        .wr_data ({held_blue_reg, sample}),
        .rd_en   (accept && flags.emit),
        .rd_addr (slot),
        .rd_data (pair)
    );

    assign sample   = clip8(s_data.raw_pixel);
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        held_blue_next = (accept && flags.load_blue) ? sample : held_blue_reg;
        if (accept && flags.emit) begin
            p1_valid_next = 1'b1;
        end else if (out_load) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_blue_reg <= '0;
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            held_blue_reg <= held_blue_next;
            p1_valid_reg  <= p1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && flags.emit) begin
            p1_red_reg <= sample;
            p1_fe_reg  <= flags.frame_end;
        end
        if (out_load) begin
            m_data_reg.blue      <= pair[15:8];
            m_data_reg.green     <= pair[7:0];
            m_data_reg.red       <= p1_red_reg;
            m_data_reg.frame_end <= p1_fe_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BQRD_ASSERT_NOW(a_stall_only_when_full, !s_ready,
        p1_valid_reg && m_valid_reg && !m_ready,
        "input stalled without a blocked pending result")
    `BQRD_ASSERT_NEXT(a_emit_reaches_stage, accept && flags.emit, p1_valid_reg,
        "accepted quad result not held in the pending stage")
    `BQRD_ASSERT_NEXT(a_no_read_after_write, accept && flags.store_pair,
        !(accept && flags.emit), "line store read right after its write")

endmodule

### src/bqrd_ram.sv
// generic single-write, single-read ram with registered read data
module bqrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/bqrd_ctrl.sv
// size registers and raster position counters of the decimator
module bqrd_ctrl import bqrd_pkg::*; #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  cfg_index_t                          cfg_index,
    input  logic [CFG_W-1:0]                    cfg_data,
    input  logic                                advance,
    input  logic                                frame_start,
    output logic [$clog2(MAX_LINE_WIDTH)-2:0]   slot,
    output ctrl_flags_t                         flags
);

    localparam int          CW    = $clog2(MAX_LINE_WIDTH);
    localparam int          SW    = CW - 1;
    localparam logic [13:0] W_MAX = 14'(MAX_LINE_WIDTH);
    localparam logic [12:0] H_MAX = 13'(MAX_FRAME_HEIGHT);

    logic [CFG_W-1:0] line_width_reg, line_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [CW-1:0]    col_eff;
    logic [ROW_W-1:0] row_eff;
    logic [13:0]      lw, w_clamped, w_last;
    logic [12:0]      h_clamped, h_even, row_step;
    logic             last_col, last_row;

    always_comb begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_LINE_WIDTH:   line_width_next   = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // sizes in effect: clamped to the legal range, forced even
    always_comb begin
        lw = {1'b0, line_width_reg};
        if (lw < 14'd2) begin
            w_clamped = 14'd2;
        end else if (lw > W_MAX) begin
            w_clamped = W_MAX;
        end else begin
            w_clamped = lw;
        end
        w_last = {w_clamped[13:1], 1'b0} - 14'd1;

        if (frame_height_reg < 13'd2) begin
            h_clamped = 13'd2;
        end else if (frame_height_reg > H_MAX) begin
            h_clamped = H_MAX;
        end else begin
            h_clamped = frame_height_reg;
        end
        h_even = {h_clamped[12:1], 1'b0};
    end

    always_comb begin
        col_eff  = frame_start ? '0 : col_reg;
        row_eff  = frame_start ? '0 : row_reg;
        last_col = 14'(col_eff) >= w_last;
        last_row = {1'b0, row_eff} >= (h_even - 13'd1);

        if (last_col) begin
            col_next = '0;
            row_step = last_row ? 13'd0 : ({1'b0, row_eff} + 13'd1);
        end else begin
            col_next = col_eff + CW'(1);
            row_step = {1'b0, row_eff};
        end
        // a shrunken height takes effect at once
        row_next = (row_step >= h_even) ? '0 : row_step[ROW_W-1:0];

        slot             = col_eff[SW:1];
        flags.load_blue  = !row_eff[0] && !col_eff[0];
        flags.store_pair = !row_eff[0] &&  col_eff[0];
        flags.emit       =  row_eff[0] &&  col_eff[0];
        flags.frame_end  = last_col && last_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
        end else begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
            if (advance) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule
